FILE: src/crle_pkg.sv
// Shared types, constants and helpers for the coefficient run-length encoder.
// No dependencies; every other file refers to it by scoped names.
package crle_pkg;

	localparam int BLOCK_ELEMS = 64;
	localparam int POS_W       = $clog2(BLOCK_ELEMS);
	localparam int ZC_W        = POS_W;
	localparam int COEF_W      = 16;
	localparam int RUN_W       = 6;
	localparam int LIM_W       = 7;
	localparam int LIM_RESET   = 16;
	localparam int LIM_MAX     = 2 ** RUN_W;
	localparam int CMP_W       = (ZC_W > LIM_W) ? ZC_W : LIM_W;
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_IDX_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

	// One classified coefficient: what the back end has to emit for it.
	typedef struct packed {
		logic                     has_value;
		logic                     has_eob;
		logic [ZC_W-1:0]          zero_count;
		logic signed [COEF_W-1:0] coef;
	} cmd_t;

	// Clamp the raw limit register into 1..LIM_MAX.
	function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] raw);
		logic [LIM_W-1:0] lim;
		lim = raw;
		if (raw == '0) begin
			lim = LIM_W'(1);
		end else if (raw > LIM_W'(LIM_MAX)) begin
			lim = LIM_W'(LIM_MAX);
		end
		return lim;
	endfunction

endpackage

FILE: src/crle_front.sv
// Front end: accepts coefficients, tracks block position and zero count,
// and classifies each item into a command. Depends on crle_pkg.
module crle_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [crle_pkg::COEF_W-1:0] coef,
	input  logic                               cmdq_full,
	output logic                               cmd_push,
	output crle_pkg::cmd_t                     cmd
);

	logic [crle_pkg::POS_W-1:0] position_q;
	logic [crle_pkg::ZC_W-1:0]  zero_count_q;
	logic                       accept;
	logic                       at_first;
	logic                       at_end;

	assign full   = cmdq_full;
	assign accept = push && !cmdq_full;

	always_comb begin
		at_first       = (position_q == '0);
		at_end         = (position_q == crle_pkg::POS_W'(crle_pkg::BLOCK_ELEMS - 1));
		cmd.has_value  = at_first || (coef != '0);
		cmd.has_eob    = at_end;
		cmd.zero_count = at_first ? '0 : zero_count_q;
		cmd.coef       = coef;
		cmd_push       = accept && (cmd.has_value || cmd.has_eob);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			zero_count_q <= '0;
		end else if (accept) begin
			// advance position, wrap at block end
			position_q <= at_end ? '0 : position_q + crle_pkg::POS_W'(1);
			// clear count on any emitted value or block end, else count the zero
			if (at_end || cmd.has_value) begin
				zero_count_q <= '0;
			end else begin
				zero_count_q <= zero_count_q + crle_pkg::ZC_W'(1);
			end
		end
	end

endmodule

FILE: src/crle_cmdq.sv
// Short command queue between front and back end.
// Depends on crle_pkg for the command type and depth.
module crle_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  crle_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output crle_pkg::cmd_t rd_data,
	output logic           empty
);

	crle_pkg::cmd_t                  mem_q [crle_pkg::CMDQ_DEPTH];
	logic [crle_pkg::CMDQ_IDX_W-1:0] wr_ptr_q;
	logic [crle_pkg::CMDQ_IDX_W-1:0] rd_ptr_q;
	logic [crle_pkg::CMDQ_CNT_W-1:0] count_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full    = (count_q == crle_pkg::CMDQ_CNT_W'(crle_pkg::CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [crle_pkg::CMDQ_IDX_W-1:0] next_ptr(
		input logic [crle_pkg::CMDQ_IDX_W-1:0] p);
		logic [crle_pkg::CMDQ_IDX_W-1:0] n;
		n = (p == crle_pkg::CMDQ_IDX_W'(crle_pkg::CMDQ_DEPTH - 1)) ? '0
			: p + crle_pkg::CMDQ_IDX_W'(1);
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + crle_pkg::CMDQ_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - crle_pkg::CMDQ_CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/crle_back.sv
// Back end: expands one command into run-limit, value and end-of-block pairs, one
// per cycle unless the output stalls, into the output register. Depends on crle_pkg.
module crle_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [crle_pkg::LIM_W-1:0]         limit,
	input  logic                               cmd_empty,
	input  crle_pkg::cmd_t                     cmd_head,
	output logic                               cmd_pop,
	output logic                               idle,
	output logic                               empty,
	input  logic                               pop,
	output logic [crle_pkg::RUN_W-1:0]         run,
	output logic signed [crle_pkg::COEF_W-1:0] amplitude,
	output logic                               end_of_block,
	output logic                               last
);

	logic                               busy_q;
	logic                               has_value_q;
	logic                               has_eob_q;
	logic signed [crle_pkg::COEF_W-1:0] coef_q;
	logic [crle_pkg::ZC_W-1:0]          rem_q;
	logic                               out_valid_q;
	logic [crle_pkg::RUN_W-1:0]         run_q;
	logic signed [crle_pkg::COEF_W-1:0] amplitude_q;
	logic                               eob_q;
	logic                               last_q;

	logic                       load;
	logic                       can_emit;
	logic                       emit_limit;
	logic [crle_pkg::CMP_W-1:0] rem_ext;
	logic [crle_pkg::CMP_W-1:0] lim_ext;
	logic [crle_pkg::CMP_W-1:0] rem_diff;

	assign load         = !busy_q && !cmd_empty;
	assign cmd_pop      = load;
	assign idle         = !busy_q;
	assign can_emit     = busy_q && (!out_valid_q || pop);
	assign rem_ext      = crle_pkg::CMP_W'(rem_q);
	assign lim_ext      = crle_pkg::CMP_W'(limit);
	assign rem_diff     = rem_ext - lim_ext;
	assign emit_limit   = has_value_q && (rem_ext >= lim_ext);

	assign empty        = !out_valid_q;
	assign run          = run_q;
	assign amplitude    = amplitude_q;
	assign end_of_block = eob_q;
	assign last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			has_value_q <= 1'b0;
			has_eob_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= 1'b1;
				has_value_q <= cmd_head.has_value;
				has_eob_q   <= cmd_head.has_eob;
			end else if (can_emit && !emit_limit) begin
				// value pair done, end-of-block pair follows if flagged; end-of-block pair done, go idle
				if (has_value_q) begin
					has_value_q <= 1'b0;
					busy_q      <= has_eob_q;
				end else begin
					busy_q <= 1'b0;
				end
			end
			if (can_emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coef_q <= cmd_head.coef;
			rem_q  <= cmd_head.zero_count;
		end else if (can_emit && emit_limit) begin
			rem_q <= crle_pkg::ZC_W'(rem_diff);
		end
		if (can_emit) begin
			if (emit_limit) begin
				run_q       <= crle_pkg::RUN_W'(limit - crle_pkg::LIM_W'(1));
				amplitude_q <= '0;
				eob_q       <= 1'b0;
				last_q      <= 1'b0;
			end else if (has_value_q) begin
				run_q       <= crle_pkg::RUN_W'(rem_q);
				amplitude_q <= coef_q;
				eob_q       <= 1'b0;
				last_q      <= !has_eob_q;
			end else begin
				run_q       <= '0;
				amplitude_q <= '0;
				eob_q       <= 1'b1;
				last_q      <= 1'b1;
			end
		end
	end

endmodule

FILE: src/coefficient_run_length_encoder_top.sv
// An accepted item goes as a command through the queue to the back end, which
// takes it and then writes its results one by one into the output register.
// The back end takes a new command only when it is through with the last one;
// items that emit no result push no command into the queue.
// Reset (arst_n low, asynchronous): block position, zero count, queue and
// output register clear; the zero-run limit returns to 16. Depends on crle_pkg.
module coefficient_run_length_encoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// coefficient input, queue style
	input  logic                               push,
	output logic                               full,
	input  logic signed [crle_pkg::COEF_W-1:0] coef,
	// result output, queue style
	output logic                               empty,
	input  logic                               pop,
	output logic [crle_pkg::RUN_W-1:0]         run,
	output logic signed [crle_pkg::COEF_W-1:0] amplitude,
	output logic                               end_of_block,
	output logic                               last,
	// zero-run limit register write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [crle_pkg::LIM_W-1:0]         cfg_data
);

	// Effective limit, clamped to 1..64 when written so the back end sees a
	// legal value directly.
	logic [crle_pkg::LIM_W-1:0] limit_q;

	logic           cmd_push;
	crle_pkg::cmd_t cmd_in;
	logic           cmdq_full;
	logic           cmd_pop;
	crle_pkg::cmd_t cmd_head;
	logic           cmdq_empty;
	logic           back_idle;

	// Accept a write only while no command waits or runs, so queued items
	// keep the limit they were sent under.
	assign cfg_ready = cmdq_empty && back_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= crle_pkg::LIM_W'(crle_pkg::LIM_RESET);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= crle_pkg::eff_limit(cfg_data);
		end
	end

	// Front: classify each coefficient, hold position and zero count.
	crle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.coef      (coef),
		.cmdq_full (cmdq_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	// Decouple the front from the back so each can stall on its own.
	crle_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmdq_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmdq_empty)
	);

	// Back: expand each command into pairs and drive the output register.
	crle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.limit        (limit_q),
		.cmd_empty    (cmdq_empty),
		.cmd_head     (cmd_head),
		.cmd_pop      (cmd_pop),
		.idle         (back_idle),
		.empty        (empty),
		.pop          (pop),
		.run          (run),
		.amplitude    (amplitude),
		.end_of_block (end_of_block),
		.last         (last)
	);

endmodule

FILE: src/crle_checker.sv
// Port-level checks for the run-length encoder, bound to the top level.
// Depends on crle_pkg and coefficient_run_length_encoder_top.
module crle_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               empty,
	input logic                               pop,
	input logic [crle_pkg::RUN_W-1:0]         run,
	input logic signed [crle_pkg::COEF_W-1:0] amplitude,
	input logic                               end_of_block,
	input logic                               last
);

	// An end-of-block pair always closes its item's beat group.
	a_eob_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && end_of_block |-> last)
		else $error("end-of-block beat without last");

	// An end-of-block pair carries run 0 and amplitude 0.
	a_eob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && end_of_block |-> run == '0 && amplitude == '0)
		else $error("end-of-block beat with nonzero payload");

	// A waiting result beat holds until popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(run) && $stable(amplitude)
			&& $stable(end_of_block) && $stable(last))
		else $error("stalled result beat changed");

endmodule

bind coefficient_run_length_encoder_top crle_checker u_crle_checker (.*);
